// ===== design/spsm_pkg.sv =====
// Shared types, register map and arithmetic helpers for the servo pulse smoother.
package spsm_pkg;

    localparam int WIDTH_W = 10;
    localparam int COUNT_W = 7;
    localparam int CMD_W   = 8;
    localparam int DIFF_W  = 12;
    localparam int ADDR_W  = 5;

    localparam logic [WIDTH_W-1:0] CENTER_RST    = 10'd375;
    localparam logic [WIDTH_W-1:0] THR_MIN_RST   = 10'd330;
    localparam logic [WIDTH_W-1:0] THR_MAX_RST   = 10'd415;
    localparam logic [WIDTH_W-1:0] STR_MIN_RST   = 10'd250;
    localparam logic [WIDTH_W-1:0] STR_MAX_RST   = 10'd500;
    localparam logic [COUNT_W-1:0] HOLD_CNT_RST  = 7'd60;
    localparam logic [COUNT_W-1:0] END_CNT_RST   = 7'd70;
    localparam logic [COUNT_W-1:0] COUNT_TOP     = 7'h7F;

    // Register index (paddr[4:2])
    localparam logic [2:0] REG_CENTER   = 3'd0;
    localparam logic [2:0] REG_THR_MIN  = 3'd1;
    localparam logic [2:0] REG_THR_MAX  = 3'd2;
    localparam logic [2:0] REG_STR_MIN  = 3'd3;
    localparam logic [2:0] REG_STR_MAX  = 3'd4;
    localparam logic [2:0] REG_HOLD_CNT = 3'd5;
    localparam logic [2:0] REG_END_CNT  = 3'd6;

    // Reciprocal multipliers; exact floor for magnitudes up to 1279
    localparam logic [10:0] DIV3_MUL   = 11'd1366;
    localparam int          DIV3_SHIFT = 12;
    localparam logic [10:0] DIV5_MUL   = 11'd1639;
    localparam int          DIV5_SHIFT = 13;

    typedef struct packed {
        logic [WIDTH_W-1:0] center;
        logic [WIDTH_W-1:0] thr_min;
        logic [WIDTH_W-1:0] thr_max;
        logic [WIDTH_W-1:0] str_min;
        logic [WIDTH_W-1:0] str_max;
        logic [COUNT_W-1:0] hold_cnt;
        logic [COUNT_W-1:0] end_cnt;
    } cfg_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] thr_width;
        logic [WIDTH_W-1:0] str_width;
        logic               braking;
        logic [COUNT_W-1:0] brake_cnt;
    } state_t;

    // Signed divide truncated toward zero, via magnitude times reciprocal
    function automatic logic signed [DIFF_W-1:0] div_trunc(
        input logic signed [DIFF_W-1:0] d,
        input logic        [10:0]       mul,
        input int                       shift
    );
        logic [DIFF_W-2:0] mag;
        logic [22:0]       prod;
        logic [DIFF_W-2:0] q;
        mag  = d[DIFF_W-1] ? (DIFF_W-1)'(-d) : d[DIFF_W-2:0];
        prod = 23'(mag) * 23'(mul);
        q    = (DIFF_W-1)'(prod >> shift);
        return d[DIFF_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    // Max test first, then min; signed so negatives land on min
    function automatic logic [WIDTH_W-1:0] clamp_width(
        input logic signed [DIFF_W-1:0] v,
        input logic        [WIDTH_W-1:0] lo,
        input logic        [WIDTH_W-1:0] hi
    );
        logic [WIDTH_W-1:0] r;
        if (v > $signed({2'b00, hi}))
            r = hi;
        else if (v < $signed({2'b00, lo}))
            r = lo;
        else
            r = v[WIDTH_W-1:0];
        return r;
    endfunction

endpackage

// ===== design/spsm_regs.sv =====
// Configuration register bank behind the APB port.
module spsm_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [spsm_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output spsm_pkg::cfg_t               cfg
);
    import spsm_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center   <= CENTER_RST;
            cfg_reg.thr_min  <= THR_MIN_RST;
            cfg_reg.thr_max  <= THR_MAX_RST;
            cfg_reg.str_min  <= STR_MIN_RST;
            cfg_reg.str_max  <= STR_MAX_RST;
            cfg_reg.hold_cnt <= HOLD_CNT_RST;
            cfg_reg.end_cnt  <= END_CNT_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_CENTER:   cfg_reg.center   <= pwdata[WIDTH_W-1:0];
                REG_THR_MIN:  cfg_reg.thr_min  <= pwdata[WIDTH_W-1:0];
                REG_THR_MAX:  cfg_reg.thr_max  <= pwdata[WIDTH_W-1:0];
                REG_STR_MIN:  cfg_reg.str_min  <= pwdata[WIDTH_W-1:0];
                REG_STR_MAX:  cfg_reg.str_max  <= pwdata[WIDTH_W-1:0];
                REG_HOLD_CNT: cfg_reg.hold_cnt <= pwdata[COUNT_W-1:0];
                REG_END_CNT:  cfg_reg.end_cnt  <= pwdata[COUNT_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_CENTER:   prdata = 32'(cfg_reg.center);
            REG_THR_MIN:  prdata = 32'(cfg_reg.thr_min);
            REG_THR_MAX:  prdata = 32'(cfg_reg.thr_max);
            REG_STR_MIN:  prdata = 32'(cfg_reg.str_min);
            REG_STR_MAX:  prdata = 32'(cfg_reg.str_max);
            REG_HOLD_CNT: prdata = 32'(cfg_reg.hold_cnt);
            REG_END_CNT:  prdata = 32'(cfg_reg.end_cnt);
            default:      prdata = 32'd0;
        endcase
    end

endmodule

// ===== design/spsm_core.sv =====
// Next-state logic: brake phase, smoothing step and clamp for both channels.
module spsm_core (
    input  spsm_pkg::cfg_t              cfg,
    input  spsm_pkg::state_t            cur,
    input  logic [spsm_pkg::CMD_W-1:0]  thr_cmd,
    input  logic [spsm_pkg::CMD_W-1:0]  str_cmd,
    output spsm_pkg::state_t            nxt
);
    import spsm_pkg::*;

    logic signed [DIFF_W-1:0] ctr_s;
    logic signed [DIFF_W-1:0] tw_s;
    logic signed [DIFF_W-1:0] sw_s;
    logic signed [DIFF_W-1:0] thr2_s;
    logic signed [DIFF_W-1:0] str2_s;
    logic signed [DIFF_W-1:0] thr_diff;
    logic signed [DIFF_W-1:0] str_diff;
    logic signed [DIFF_W-1:0] thr_sum;
    logic signed [DIFF_W-1:0] str_sum;
    logic                     thr_neg;
    logic                     in_phase;
    logic [COUNT_W-1:0]       cnt_inc;

    assign ctr_s   = $signed({2'b00, cfg.center});
    assign tw_s    = $signed({2'b00, cur.thr_width});
    assign sw_s    = $signed({2'b00, cur.str_width});
    assign thr2_s  = $signed({{3{thr_cmd[CMD_W-1]}}, thr_cmd, 1'b0});
    assign str2_s  = $signed({{3{str_cmd[CMD_W-1]}}, str_cmd, 1'b0});
    assign thr_neg = thr_cmd[CMD_W-1];

    // Phase entry uses the width from before this update
    assign in_phase = (cur.thr_width >= cfg.center && thr_neg) || cur.braking;
    assign cnt_inc  = (cur.brake_cnt < COUNT_TOP) ? cur.brake_cnt + COUNT_W'(1) : cur.brake_cnt;

    assign str_diff = ctr_s + str2_s - sw_s;
    assign str_sum  = sw_s + div_trunc(str_diff, DIV5_MUL, DIV5_SHIFT);

    always_comb
    begin
        thr_diff      = ctr_s + thr2_s - tw_s;
        nxt.braking   = cur.braking;
        nxt.brake_cnt = cur.brake_cnt;
        if (in_phase)
        begin
            if (thr_neg)
            begin
                nxt.braking   = 1'b1;
                nxt.brake_cnt = cnt_inc;
                if (cnt_inc > cfg.hold_cnt)
                    thr_diff = ctr_s - tw_s;
                if (cnt_inc > cfg.end_cnt)
                begin
                    nxt.braking   = 1'b0;
                    nxt.brake_cnt = '0;
                end
            end
            else
            begin
                nxt.braking   = 1'b0;
                nxt.brake_cnt = '0;
            end
        end
        thr_sum       = tw_s + div_trunc(thr_diff, DIV3_MUL, DIV3_SHIFT);
        nxt.thr_width = clamp_width(thr_sum, cfg.thr_min, cfg.thr_max);
        nxt.str_width = clamp_width(str_sum, cfg.str_min, cfg.str_max);
    end

endmodule

// ===== design/servo_pulse_smoother_with_esc_brake.sv =====
// Top level of the servo pulse smoother with reversing-ESC brake phase.
//
// Each input transaction carries a signed throttle and steering command; each
// yields exactly one output transaction with the new smoothed pulse widths and
// the brake flag. One transaction is accepted per clock cycle when the output
// side keeps up; an accepted transaction passes through the input register and
// then the result register, and m_tvalid rises when the result register loads.
// The pulse widths and brake counter are updated in the same cycle that the
// result register loads, so the next command already sees them. A stall on
// the output side fills the input register and then drops s_tready. Config
// registers should only be written while no transaction is in flight.
module servo_pulse_smoother_with_esc_brake (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [7:0] throttle_cmd, [15:8] steering_cmd
    // pulse stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // [9:0] throttle_pulse, [19:10] steering_pulse, rest 0
    output logic [0:0]  m_tuser   // [0] brake_active
);
    import spsm_pkg::*;

    cfg_t               cfg;
    state_t             state_reg;
    state_t             state_next;

    logic               in_valid_reg;
    logic [CMD_W-1:0]   in_thr_reg;
    logic [CMD_W-1:0]   in_str_reg;
    logic               out_valid_reg;
    logic [WIDTH_W-1:0] out_thr_reg;
    logic [WIDTH_W-1:0] out_str_reg;
    logic               out_brake_reg;
    logic               advance;
    logic               in_take;

    spsm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spsm_core u_core (
        .cfg     (cfg),
        .cur     (state_reg),
        .thr_cmd (in_thr_reg),
        .str_cmd (in_str_reg),
        .nxt     (state_next)
    );

    // Input register moves into the result register when that is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_thr_reg <= s_tdata[7:0];
            in_str_reg <= s_tdata[15:8];
        end
    end

    // Smoother state commits together with the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.thr_width <= CENTER_RST;
            state_reg.str_width <= CENTER_RST;
            state_reg.braking   <= 1'b0;
            state_reg.brake_cnt <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_thr_reg   <= state_next.thr_width;
            out_str_reg   <= state_next.str_width;
            out_brake_reg <= state_next.braking;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {4'b0000, out_str_reg, out_thr_reg};
    assign m_tuser[0] = out_brake_reg;

    // Brake counter is zero whenever the phase is off
    assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.braking |-> state_reg.brake_cnt == '0)
        else $error("brake counter nonzero outside brake phase");

    // A non-negative throttle command always ends the phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_thr_reg[CMD_W-1]) |=> !state_reg.braking)
        else $error("brake phase survived non-negative throttle");

    // Pending result always matches the committed state
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_thr_reg == state_reg.thr_width &&
                           out_str_reg == state_reg.str_width &&
                           out_brake_reg == state_reg.braking))
        else $error("result register out of step with smoother state");

    // A free result register never blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

// ===== dv/servo_pulse_smoother_with_esc_brake_test.sv =====
// Self-checking testbench for the servo pulse smoother with reversing-ESC brake phase.
module servo_pulse_smoother_with_esc_brake_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spsm_pkg::*;

    // Index past the end of the register map; writes there must be dropped
    localparam logic [2:0] REG_SPARE = 3'd7;

    typedef logic signed [CMD_W-1:0] cmd_t;

    // One expected pulse transaction
    typedef struct packed {
        logic [WIDTH_W-1:0] thr;
        logic [WIDTH_W-1:0] str;
        logic               brake;
    } pulse_set_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;  // [7:0] throttle_cmd, [15:8] steering_cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // [9:0] throttle_pulse, [19:10] steering_pulse, rest 0
    logic [0:0]  m_tuser;        // [0] brake_active

    servo_pulse_smoother_with_esc_brake dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Shadow copy of the block: register file and smoothing state
    cfg_t       shadow_cfg;
    state_t     smoother_st;
    pulse_set_t pulse_q[$];   // pulse transactions still owed by the block

    int errors          = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int brake_entries   = 0;
    int send_idle_pct   = 9;
    int recv_idle_pct   = 61;
    int stall_left      = 0;  // forced receiver hold-off, in cycles

    initial forever #10 clk = ~clk;

    // Hard stop in case the handshakes hang
    initial
    begin
        #4ms;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (errors < 20)
            $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void shadow_reset();
        shadow_cfg = '{center: CENTER_RST, thr_min: THR_MIN_RST, thr_max: THR_MAX_RST,
                       str_min: STR_MIN_RST, str_max: STR_MAX_RST,
                       hold_cnt: HOLD_CNT_RST, end_cnt: END_CNT_RST};
        smoother_st = '{thr_width: CENTER_RST, str_width: CENTER_RST,
                        braking: 1'b0, brake_cnt: '0};
    endfunction

    function automatic void shadow_write(input logic [2:0] idx, input logic [31:0] value);
        case (idx)
            REG_CENTER:   shadow_cfg.center   = value[WIDTH_W-1:0];
            REG_THR_MIN:  shadow_cfg.thr_min  = value[WIDTH_W-1:0];
            REG_THR_MAX:  shadow_cfg.thr_max  = value[WIDTH_W-1:0];
            REG_STR_MIN:  shadow_cfg.str_min  = value[WIDTH_W-1:0];
            REG_STR_MAX:  shadow_cfg.str_max  = value[WIDTH_W-1:0];
            REG_HOLD_CNT: shadow_cfg.hold_cnt = value[COUNT_W-1:0];
            REG_END_CNT:  shadow_cfg.end_cnt  = value[COUNT_W-1:0];
            default: ;  // unmapped: ignored
        endcase
    endfunction

    function automatic logic [31:0] shadow_read(input logic [2:0] idx);
        case (idx)
            REG_CENTER:   return 32'(shadow_cfg.center);
            REG_THR_MIN:  return 32'(shadow_cfg.thr_min);
            REG_THR_MAX:  return 32'(shadow_cfg.thr_max);
            REG_STR_MIN:  return 32'(shadow_cfg.str_min);
            REG_STR_MAX:  return 32'(shadow_cfg.str_max);
            REG_HOLD_CNT: return 32'(shadow_cfg.hold_cnt);
            REG_END_CNT:  return 32'(shadow_cfg.end_cnt);
            default:      return '0;
        endcase
    endfunction

    // Max bound wins when min > max; signed so negative values land on min
    function automatic int limit_width(input int v, input int lo, input int hi);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // One smoothing update; advances the shadow state and returns the pulses
    function automatic pulse_set_t smooth_step(input cmd_t thr_cmd, input cmd_t str_cmd);
        int         thr;
        int         str;
        int         ctr;
        int         tw;
        int         sw;
        int         delta;
        pulse_set_t res;
        thr   = thr_cmd;
        str   = str_cmd;
        ctr   = shadow_cfg.center;
        tw    = smoother_st.thr_width;
        sw    = smoother_st.str_width;
        delta = ctr + 2 * thr - tw;
        // Brake decision looks at the width from before this update
        if ((tw >= ctr && thr < 0) || smoother_st.braking)
        begin
            if (!smoother_st.braking)
                brake_entries++;
            smoother_st.braking = 1'b1;
            if (smoother_st.brake_cnt != COUNT_TOP)
                smoother_st.brake_cnt++;
            if (thr < 0)
            begin
                // hold test before end test; both may hit in one update
                if (smoother_st.brake_cnt > shadow_cfg.hold_cnt)
                    delta = ctr - tw;
                if (smoother_st.brake_cnt > shadow_cfg.end_cnt)
                begin
                    smoother_st.braking   = 1'b0;
                    smoother_st.brake_cnt = '0;
                end
            end
            else
            begin
                smoother_st.braking   = 1'b0;
                smoother_st.brake_cnt = '0;
            end
        end
        // SV integer divide truncates toward zero
        smoother_st.thr_width = WIDTH_W'(limit_width(tw + delta / 3,
                                                     shadow_cfg.thr_min, shadow_cfg.thr_max));
        delta = ctr + 2 * str - sw;
        smoother_st.str_width = WIDTH_W'(limit_width(sw + delta / 5,
                                                     shadow_cfg.str_min, shadow_cfg.str_max));
        res.thr   = smoother_st.thr_width;
        res.str   = smoother_st.str_width;
        res.brake = smoother_st.braking;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Bus drivers
    // ------------------------------------------------------------------

    // APB read; data sampled in the access phase at the completing edge
    task automatic check_reg(input logic [2:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== shadow_read(idx))
            flag_mismatch("register readback", prdata, shadow_read(idx));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // APB write, followed by a readback of mapped registers.
    // Only called with no command transaction in flight.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        shadow_write(idx, value);
        reg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (idx <= REG_END_CNT)
            check_reg(idx);
    endtask

    // Offer one command transaction; predict once the block takes it
    task automatic send_cmd(input cmd_t thr, input cmd_t str);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {str, thr};
        do
            @(posedge clk);
        while (!s_tready);
        pulse_q.push_back(smooth_step(thr, str));
        items_sent++;
    endtask

    // Drop s_tvalid and let every owed pulse transaction come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pulse_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Receiver: random stalls, or a forced hold-off while stall_left runs down
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Checker: every accepted pulse transaction against the oldest prediction
    always @(posedge clk)
    begin
        pulse_set_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            results_checked++;
            if (pulse_q.size() == 0)
                flag_mismatch("pulse transaction with nothing pending", m_tdata, 0);
            else
            begin
                want = pulse_q.pop_front();
                if (m_tdata[9:0] !== want.thr)
                    flag_mismatch("throttle_pulse", m_tdata[9:0], want.thr);
                if (m_tdata[19:10] !== want.str)
                    flag_mismatch("steering_pulse", m_tdata[19:10], want.str);
                if (m_tuser[0] !== want.brake)
                    flag_mismatch("brake_active", m_tuser[0], want.brake);
                if (m_tdata[23:20] !== 4'b0)
                    flag_mismatch("tdata padding", m_tdata[23:20], 0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic cmd_t pick_edge();
        case ($urandom_range(4))
            0:       return -8'sd128;
            1:       return -8'sd1;
            2:       return 8'sd0;
            3:       return 8'sd1;
            default: return 8'sd127;
        endcase
    endfunction

    // Counts: mostly short so the brake phase runs through, sometimes the top
    function automatic logic [31:0] pick_count();
        logic [COUNT_W-1:0] n;
        case ($urandom_range(9))
            0:       n = COUNT_TOP;
            1:       n = COUNT_W'($urandom_range(13, 126));
            default: n = COUNT_W'($urandom_range(0, 12));
        endcase
        return {25'($urandom), n};  // junk above the field must be dropped
    endfunction

    // Clamp bounds around center, occasionally anything (including min > max)
    function automatic logic [31:0] pick_bound(input int ctr, input bit upper);
        int v;
        if ($urandom_range(9) == 0)
            v = $urandom_range(1023);
        else if (upper)
            v = ctr + $urandom_range(0, 300);
        else
            v = ctr - $urandom_range(0, 300);
        v = (v < 0) ? 0 : (v > 1023) ? 1023 : v;
        return {22'($urandom), 10'(v)};
    endfunction

    task automatic shuffle_config();
        int ctr;
        drain();
        case ($urandom_range(9))
            0:       ctr = $urandom_range(0, 255);
            1:       ctr = $urandom_range(768, 1023);
            default: ctr = $urandom_range(256, 767);
        endcase
        write_reg(REG_CENTER, {22'($urandom), 10'(ctr)});
        write_reg(REG_THR_MIN, pick_bound(ctr, 1'b0));
        write_reg(REG_THR_MAX, pick_bound(ctr, 1'b1));
        write_reg(REG_STR_MIN, pick_bound(ctr, 1'b0));
        write_reg(REG_STR_MAX, pick_bound(ctr, 1'b1));
        write_reg(REG_HOLD_CNT, pick_count());
        write_reg(REG_END_CNT, pick_count());
    endtask

    // Push the throttle above center, then reverse for a random run of up to the
    // end count plus four commands (at most 40), now and then releasing early
    task automatic brake_burst();
        int n;
        int cap;
        repeat ($urandom_range(1, 6))
            send_cmd(cmd_t'($urandom_range(1, 127)), cmd_t'($urandom));
        cap = shadow_cfg.end_cnt + 4;
        n   = $urandom_range(1, (cap > 40) ? 40 : cap);
        repeat (n)
        begin
            if ($urandom_range(11) == 0)
                send_cmd(cmd_t'($urandom_range(0, 127)), cmd_t'($urandom));
            else
                send_cmd(cmd_t'(-$urandom_range(1, 128)), cmd_t'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes at reset configuration
    task automatic test_field_extremes();
        send_cmd(8'sd127, 8'sd127);
        send_cmd(8'sd127, -8'sd128);
        send_cmd(-8'sd128, 8'sd127);
        send_cmd(-8'sd128, -8'sd128);
        send_cmd(8'sd0, 8'sd0);
        send_cmd(-8'sd1, 8'sd1);
    endtask

    // Short hold/end counts: hold to center, end, release; coinciding counts;
    // zero counts end the phase on its first update
    task automatic test_brake_phase();
        drain();
        write_reg(REG_CENTER, 32'd375);
        write_reg(REG_THR_MIN, 32'd0);
        write_reg(REG_THR_MAX, 32'd1023);
        write_reg(REG_STR_MIN, 32'd0);
        write_reg(REG_STR_MAX, 32'd1023);
        write_reg(REG_HOLD_CNT, 32'd2);
        write_reg(REG_END_CNT, 32'd4);
        repeat (2) send_cmd(8'sd60, 8'sd0);
        repeat (6) send_cmd(-8'sd80, 8'sd0);
        send_cmd(8'sd10, 8'sd0);
        drain();
        write_reg(REG_HOLD_CNT, 32'd3);
        write_reg(REG_END_CNT, 32'd3);
        repeat (2) send_cmd(8'sd60, 8'sd0);
        repeat (5) send_cmd(-8'sd80, 8'sd0);
        drain();
        write_reg(REG_HOLD_CNT, 32'd0);
        write_reg(REG_END_CNT, 32'd0);
        send_cmd(8'sd60, 8'sd0);
        repeat (2) send_cmd(-8'sd80, 8'sd0);
    endtask

    // Clamp corners: min above max, target below zero, top of the range
    task automatic test_clamp_corners();
        drain();
        write_reg(REG_THR_MIN, 32'd600);
        write_reg(REG_THR_MAX, 32'd100);
        write_reg(REG_STR_MIN, 32'd1023);
        write_reg(REG_STR_MAX, 32'd0);
        send_cmd(8'sd0, 8'sd0);
        send_cmd(8'sd127, -8'sd128);
        drain();
        write_reg(REG_CENTER, 32'd0);
        write_reg(REG_THR_MIN, 32'd5);
        write_reg(REG_THR_MAX, 32'd1023);
        write_reg(REG_STR_MIN, 32'd5);
        write_reg(REG_STR_MAX, 32'd1023);
        repeat (2) send_cmd(-8'sd128, -8'sd128);
        drain();
        write_reg(REG_CENTER, 32'd1023);
        send_cmd(8'sd127, 8'sd127);
    endtask

    // Unmapped index and out-of-field data bits are dropped
    task automatic test_register_map();
        drain();
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        write_reg(REG_CENTER, 32'hFFFF_FD77);
        write_reg(REG_HOLD_CNT, 32'hFFFF_FF85);
        for (int i = 0; i <= REG_END_CNT; i++)
            check_reg(3'(i));
    endtask

    // Counts of 127 are never exceeded by the saturating counter: phase lasts until release
    task automatic test_counter_saturation();
        drain();
        write_reg(REG_CENTER, 32'd375);
        write_reg(REG_THR_MIN, 32'd0);
        write_reg(REG_THR_MAX, 32'd1023);
        write_reg(REG_HOLD_CNT, 32'hFFFF_FFFF);
        write_reg(REG_END_CNT, 32'h0000_007F);
        repeat (3) send_cmd(8'sd100, cmd_t'($urandom));
        repeat (140) send_cmd(cmd_t'(-$urandom_range(1, 128)), cmd_t'($urandom));
        send_cmd(8'sd0, cmd_t'($urandom));
    endtask

    // Receiver holds off long enough for the block to fill and stall input
    task automatic test_backpressure();
        int saved_pct;
        drain();
        saved_pct     = send_idle_pct;
        send_idle_pct = 0;
        stall_left    = 100;
        repeat (30) send_cmd(cmd_t'($urandom), cmd_t'($urandom));
        send_idle_pct = saved_pct;
        drain();
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct, input int count);
        int goal;
        int next_cfg;
        drain();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        goal     = items_sent + count;
        next_cfg = items_sent;
        while (items_sent < goal)
        begin
            if (items_sent >= next_cfg)
            begin
                shuffle_config();
                next_cfg = items_sent + $urandom_range(100, 200);
            end
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5:
                    brake_burst();
                6, 7:
                    repeat ($urandom_range(1, 8))
                        send_cmd(cmd_t'($urandom), cmd_t'($urandom));
                default:
                    repeat ($urandom_range(1, 4))
                        send_cmd(pick_edge(), cmd_t'($urandom));
            endcase
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        shadow_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_brake_phase();
        test_clamp_corners();
        test_register_map();
        test_counter_saturation();
        test_backpressure();
        test_random_phase(9, 61, 540);
        test_random_phase(61, 9, 540);
        test_random_phase(0, 0, 540);

        drain();
        repeat (8) @(posedge clk);
        $display("Run covered %0d command transactions, %0d pulse transactions checked,",
                 items_sent, results_checked);
        $display("%0d register writes and %0d brake phases entered.",
                 reg_writes, brake_entries);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
